// File: sv/luhn_pkg.sv
// ============================================================================
// luhn_pkg
// Shared types, constants and helper functions for the Luhn card classifier.
// ============================================================================
`default_nettype none

package luhn_pkg;

    // input and digit sizes
    localparam int CARD_W     = 63;
    localparam int BIN_W      = 64;
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 19;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int COUNT_W    = 5;
    localparam int SUM_W      = 4;
    localparam int BRAND_W    = 2;

    // conversion unit: bits shifted in per cycle and number of cycles
    localparam int CONV_BITS  = 4;
    localparam int CONV_STEPS = BIN_W / CONV_BITS;
    localparam int CONV_CNT_W = $clog2(CONV_STEPS);

    localparam int DEFAULT_MAX_DIGITS = 19;

    // brand codes
    localparam logic [BRAND_W-1:0] BRAND_INVALID    = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_AMEX       = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_MASTERCARD = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_VISA       = 2'd3;

    // brand prefixes and lengths
    localparam logic [DIGIT_W-1:0] AMEX_LEAD   = 4'd3;
    localparam logic [DIGIT_W-1:0] AMEX_NEXT_A = 4'd4;
    localparam logic [DIGIT_W-1:0] AMEX_NEXT_B = 4'd7;
    localparam logic [DIGIT_W-1:0] MC_LEAD     = 4'd5;
    localparam logic [DIGIT_W-1:0] MC_NEXT_LO  = 4'd1;
    localparam logic [DIGIT_W-1:0] MC_NEXT_HI  = 4'd5;
    localparam logic [DIGIT_W-1:0] VISA_LEAD   = 4'd4;
    localparam logic [COUNT_W-1:0] AMEX_LEN    = 5'd15;
    localparam logic [COUNT_W-1:0] MC_LEN      = 5'd16;
    localparam logic [COUNT_W-1:0] VISA_LEN_A  = 5'd13;
    localparam logic [COUNT_W-1:0] VISA_LEN_B  = 5'd16;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PEEL
    } t_state;

    // status from the digit accumulator
    typedef struct packed {
        logic                rest_nz;
        logic [COUNT_W-1:0]  count;
        logic [SUM_W-1:0]    sum_mod;
        logic [DIGIT_W-1:0]  top;
        logic [DIGIT_W-1:0]  below;
    } t_acc_status;

    // luhn weight of one digit: odd positions are doubled and folded
    function automatic logic [DIGIT_W-1:0] digit_weight(
        input logic [DIGIT_W-1:0] d,
        input logic               odd
    );
        logic [DIGIT_W:0] dbl;
        dbl = {d, 1'b0};
        if (!odd) begin
            return d;
        end else if (dbl > 5'd9) begin
            return DIGIT_W'(dbl - 5'd9);
        end else begin
            return dbl[DIGIT_W-1:0];
        end
    endfunction

    // brand from the two leading digits and the digit count
    function automatic logic [BRAND_W-1:0] pick_brand(
        input logic [DIGIT_W-1:0] lead1,
        input logic [DIGIT_W-1:0] lead2,
        input logic [COUNT_W-1:0] count
    );
        if (lead1 == AMEX_LEAD && (lead2 == AMEX_NEXT_A || lead2 == AMEX_NEXT_B)
                && count == AMEX_LEN) begin
            return BRAND_AMEX;
        end else if (lead1 == MC_LEAD && lead2 inside {[MC_NEXT_LO:MC_NEXT_HI]}
                && count == MC_LEN) begin
            return BRAND_MASTERCARD;
        end else if (lead1 == VISA_LEAD && (count == VISA_LEN_A || count == VISA_LEN_B)) begin
            return BRAND_VISA;
        end else begin
            return BRAND_INVALID;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/luhn_bcd_conv.sv
// ============================================================================
// luhn_bcd_conv
// Iterative binary to BCD converter (shift and add-3), four bits per cycle.
// ============================================================================
`default_nettype none

module luhn_bcd_conv
    import luhn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [CARD_W-1:0] i_value,
    output logic                   o_done,
    output logic [BCD_W-1:0]       o_bcd
);

    logic [BIN_W-1:0]      r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [CONV_CNT_W-1:0] r_cnt;
    logic                  r_run;
    logic                  r_done;

    // four shift and add-3 steps on the bcd digits
    always_comb begin
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
        bcd = r_bcd;
        bin = r_bin;
        for (int s = 0; s < CONV_BITS; s++) begin
            for (int k = 0; k < BCD_DIGITS; k++) begin
                if (bcd[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                    bcd[k*DIGIT_W +: DIGIT_W] = bcd[k*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[BIN_W-1]};
            bin = {bin[BIN_W-2:0], 1'b0};
        end
        n_bcd = bcd;
        n_bin = bin;
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CONV_CNT_W'(CONV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= BIN_W'(i_value);
            r_bcd <= '0;
        end else if (r_run) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

// File: sv/luhn_digit_acc.sv
// ============================================================================
// luhn_digit_acc
// Peels one bcd digit per cycle while i_step is high and keeps the Luhn sum, count and leading digits.
// ============================================================================
`default_nettype none

module luhn_digit_acc
    import luhn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_load,
    input  wire logic             i_step,
    input  wire logic [BCD_W-1:0] i_bcd,
    output t_acc_status           o_status
);

    logic [BCD_W-1:0]   r_rest;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [DIGIT_W-1:0] r_top;
    logic [DIGIT_W-1:0] r_below;
    logic [DIGIT_W-1:0] digit;
    logic [DIGIT_W-1:0] weight;
    logic [SUM_W:0]     sum_raw;
    logic [SUM_W-1:0]   n_sum;

    // weight of the low digit and running sum modulo 10
    assign digit   = r_rest[DIGIT_W-1:0];
    assign weight  = digit_weight(digit, r_count[0]);
    assign sum_raw = {1'b0, r_sum} + {1'b0, weight};
    assign n_sum   = (sum_raw >= 5'd10) ? SUM_W'(sum_raw - 5'd10) : sum_raw[SUM_W-1:0];

    // accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rest  <= i_bcd;
            r_count <= '0;
            r_sum   <= '0;
            r_top   <= '0;
            r_below <= '0;
        end else if (i_step) begin
            r_rest  <= {{DIGIT_W{1'b0}}, r_rest[BCD_W-1:DIGIT_W]};
            r_count <= r_count + 1'b1;
            r_sum   <= n_sum;
            r_below <= r_top;
            r_top   <= digit;
        end
    end

    assign o_status.rest_nz = |r_rest;
    assign o_status.count   = r_count;
    assign o_status.sum_mod = r_sum;
    assign o_status.top     = r_top;
    assign o_status.below   = r_below;

endmodule

`default_nettype wire

// File: sv/luhn_card_number_classifier.sv
// ============================================================================
// luhn_card_number_classifier
// Luhn check and brand classification of a binary card number.
//
//   channel   signals                                  direction
//   request   start, busy (out), i_card_number         in
//   result    o_valid, o_brand, o_luhn_ok, o_digit_count  out
//
// A request runs the binary to bcd conversion, a load step, then one peel
// step per digit (up to MAX_DIGITS) and a closing step. The conversion unit
// shifts four bits a cycle and the accumulator peels one digit a cycle.
// start is taken only in idle; busy is high from acceptance until the result
// strobe. o_valid is high for one cycle and the receiver cannot stall it.
// Reset is synchronous and active low; it returns the sequencer to idle.
// ============================================================================
`default_nettype none

module luhn_card_number_classifier
    import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [CARD_W-1:0]  i_card_number,
    output logic                    o_valid,
    output logic [BRAND_W-1:0]      o_brand,
    output logic                    o_luhn_ok,
    output logic [COUNT_W-1:0]      o_digit_count
);

    t_state             r_state, n_state;
    logic               conv_start;
    logic               conv_done;
    logic [BCD_W-1:0]   conv_bcd;
    logic               acc_load;
    logic               acc_step;
    t_acc_status        acc_st;
    logic               finish;
    logic               n_ok;
    logic [BRAND_W-1:0] n_brand;
    logic               r_valid;
    logic [BRAND_W-1:0] r_brand;
    logic               r_ok;
    logic [COUNT_W-1:0] r_count;

    luhn_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_value (i_card_number),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    luhn_digit_acc u_acc (
        .i_clk    (i_clk),
        .i_load   (acc_load),
        .i_step   (acc_step),
        .i_bcd    (conv_bcd),
        .o_status (acc_st)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and unit controls
    always_comb begin
        n_state    = r_state;
        conv_start = 1'b0;
        acc_load   = 1'b0;
        acc_step   = 1'b0;
        finish     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    conv_start = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    acc_load = 1'b1;
                    n_state  = ST_PEEL;
                end
            end
            ST_PEEL: begin
                if (acc_st.rest_nz && acc_st.count < COUNT_W'(MAX_DIGITS)) begin
                    acc_step = 1'b1;
                end else begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // classify on the closing cycle
    always_comb begin
        n_ok    = !acc_st.rest_nz && (acc_st.sum_mod == '0);
        n_brand = BRAND_INVALID;
        if (n_ok && acc_st.count >= 5'd2) begin
            n_brand = pick_brand(acc_st.top, acc_st.below, acc_st.count);
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= finish;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_brand <= n_brand;
            r_ok    <= n_ok;
            r_count <= acc_st.count;
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_brand       = r_brand;
    assign o_luhn_ok     = r_ok;
    assign o_digit_count = r_count;

endmodule

`default_nettype wire
